FILE: sv/ccfe_pkg.sv
// Clock/calendar field editor: shared types, command and field codes,
// limits and the month-length function. No dependencies.
package ccfe_pkg;

    localparam int CMD_W   = 3;
    localparam int FLD_W   = 3;
    localparam int VAL_W   = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 12;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int IDLE_W  = 16;

    localparam logic [CMD_W-1:0] CMD_SELECT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;

    localparam logic [FLD_W-1:0] FLD_NONE   = 3'd0;
    localparam logic [FLD_W-1:0] FLD_MONTH  = 3'd1;
    localparam logic [FLD_W-1:0] FLD_DAY    = 3'd2;
    localparam logic [FLD_W-1:0] FLD_YEAR   = 3'd3;
    localparam logic [FLD_W-1:0] FLD_HOUR   = 3'd4;
    localparam logic [FLD_W-1:0] FLD_MINUTE = 3'd5;
    localparam logic [FLD_W-1:0] FLD_SECOND = 3'd6;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd2000;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd2099;
    localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;
    localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd3000;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [FLD_W-1:0] fld;
        logic [VAL_W-1:0] val;
    } item_t;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [FLD_W-1:0]   selected;
        logic               buttons;
        logic [IDLE_W-1:0]  idle;
    } cal_state_t;

    // Month length; out-of-range month treated as January.
    function automatic logic [DAY_W-1:0] days_in_month(
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year
    );
        logic [DAY_W-1:0] n;
        case (month)
            4'd2:    n = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

FILE: sv/ccfe_in_stage.sv
// Clock/calendar field editor: input register for one transaction.
// Depends on ccfe_pkg.
module ccfe_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ccfe_pkg::CMD_W-1:0] command,
    input  logic [ccfe_pkg::FLD_W-1:0] field_number,
    input  logic [ccfe_pkg::VAL_W-1:0] field_value,
    input  logic                  advance,
    output logic                  item_valid,
    output ccfe_pkg::item_t       item
);
    import ccfe_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{cmd: command, fld: field_number, val: field_value};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: sv/ccfe_field_update.sv
// Clock/calendar field editor: next-state logic for one transaction
// (select, up/down wrap/clamp, tick timeout, range-checked write).
// Depends on ccfe_pkg.
module ccfe_field_update (
    input  ccfe_pkg::cal_state_t            cur,
    input  ccfe_pkg::item_t                 item,
    input  logic [ccfe_pkg::IDLE_W-1:0]     timeout,
    output ccfe_pkg::cal_state_t            nxt
);
    import ccfe_pkg::*;

    logic [DAY_W-1:0]  mlen;
    logic [DAY_W:0]    day_inc;
    logic [IDLE_W-1:0] idle_inc;
    logic              up;

    assign mlen     = days_in_month(cur.month, cur.year);
    assign day_inc  = {1'b0, cur.day} + 6'd1;
    assign idle_inc = (cur.idle == IDLE_MAX) ? cur.idle : cur.idle + 16'd1;
    assign up       = (item.cmd == CMD_UP);

    always_comb
    begin
        nxt = cur;
        case (item.cmd)
            CMD_SELECT:
            begin
                if (item.fld inside {[FLD_MONTH:FLD_SECOND]})
                begin
                    nxt.selected = item.fld;
                    nxt.buttons  = 1'b1;
                    nxt.idle     = '0;
                end
            end
            CMD_UP, CMD_DOWN:
            begin
                nxt.idle = '0;
                case (cur.selected)
                    FLD_MONTH:
                    begin
                        if (up)
                            nxt.month = (cur.month >= 4'd12) ? 4'd1 : cur.month + 4'd1;
                        else
                            nxt.month = (cur.month <= 4'd1) ? 4'd12 : cur.month - 4'd1;
                    end
                    FLD_DAY:
                    begin
                        if (up)
                            nxt.day = (day_inc > {1'b0, mlen}) ? 5'd1 : day_inc[DAY_W-1:0];
                        else
                            nxt.day = (cur.day <= 5'd1) ? mlen : cur.day - 5'd1;
                    end
                    FLD_YEAR:
                    begin
                        if (up && cur.year < YEAR_MAX)
                            nxt.year = cur.year + 12'd1;
                        else if (!up && cur.year > YEAR_MIN)
                            nxt.year = cur.year - 12'd1;
                    end
                    FLD_HOUR:
                    begin
                        if (up)
                            nxt.hour = (cur.hour >= 5'd23) ? 5'd0 : cur.hour + 5'd1;
                        else
                            nxt.hour = (cur.hour == 5'd0 || cur.hour > 5'd23) ?
                                       5'd23 : cur.hour - 5'd1;
                    end
                    FLD_MINUTE:
                    begin
                        if (up)
                            nxt.minute = (cur.minute >= 6'd59) ? 6'd0 : cur.minute + 6'd1;
                        else
                            nxt.minute = (cur.minute == 6'd0 || cur.minute > 6'd59) ?
                                         6'd59 : cur.minute - 6'd1;
                    end
                    FLD_SECOND:
                    begin
                        if (up)
                            nxt.second = (cur.second >= 6'd59) ? 6'd0 : cur.second + 6'd1;
                        else
                            nxt.second = (cur.second == 6'd0 || cur.second > 6'd59) ?
                                         6'd59 : cur.second - 6'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_TICK:
            begin
                if (cur.buttons)
                begin
                    if (idle_inc >= timeout)
                    begin
                        nxt.selected = FLD_NONE;
                        nxt.buttons  = 1'b0;
                        nxt.idle     = '0;
                    end
                    else
                    begin
                        nxt.idle = idle_inc;
                    end
                end
            end
            CMD_WRITE:
            begin
                case (item.fld)
                    FLD_MONTH:
                        if (item.val inside {[12'd1:12'd12]})
                            nxt.month = item.val[MONTH_W-1:0];
                    FLD_DAY:
                        if (item.val inside {[12'd1:12'd31]})
                            nxt.day = item.val[DAY_W-1:0];
                    FLD_YEAR:
                        if (item.val inside {[YEAR_MIN:YEAR_MAX]})
                            nxt.year = item.val;
                    FLD_HOUR:
                        if (item.val <= 12'd23)
                            nxt.hour = item.val[HOUR_W-1:0];
                    FLD_MINUTE:
                        if (item.val <= 12'd59)
                            nxt.minute = item.val[MIN_W-1:0];
                    FLD_SECOND:
                        if (item.val <= 12'd59)
                            nxt.second = item.val[SEC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: sv/clock_calendar_field_editor_unit.sv
// Clock/calendar field editor top level: input stage, calendar state /
// result register and the timeout register. Depends on ccfe_pkg,
// ccfe_in_stage and ccfe_field_update.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   command, field_number, field_value
//   result   out        out_valid / out_stall month_now ... buttons_visible
//   config   in         cfg_we                cfg_wdata (idle timeout ticks)
//
// One transaction per cycle unless the result stalls.
// The calendar registers double as the result register: they update when
// a transaction leaves the input stage, so state and result stay in step.
// A stalled result holds the input stage, which then raises in_stall.
// Reset sets 01/01/2000 00:00:00, no selection, timeout 3000.
module clock_calendar_field_editor_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ccfe_pkg::CMD_W-1:0]      command,
    input  logic [ccfe_pkg::FLD_W-1:0]      field_number,
    input  logic [ccfe_pkg::VAL_W-1:0]      field_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ccfe_pkg::MONTH_W-1:0]    month_now,
    output logic [ccfe_pkg::DAY_W-1:0]      day_now,
    output logic [ccfe_pkg::YEAR_W-1:0]     year_now,
    output logic [ccfe_pkg::HOUR_W-1:0]     hour_now,
    output logic [ccfe_pkg::MIN_W-1:0]      minute_now,
    output logic [ccfe_pkg::SEC_W-1:0]      second_now,
    output logic [ccfe_pkg::FLD_W-1:0]      selected_now,
    output logic                            buttons_visible,
    input  logic                            cfg_we,
    input  logic [ccfe_pkg::IDLE_W-1:0]     cfg_wdata
);
    import ccfe_pkg::*;

    logic              item_valid;
    item_t             item;
    logic              advance;
    cal_state_t        state_reg;
    cal_state_t        state_next;
    cal_state_t        state_upd;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [IDLE_W-1:0] timeout_reg;
    logic [IDLE_W-1:0] timeout_next;

    assign advance = item_valid && (!out_valid_reg || !out_stall);

    ccfe_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .field_number (field_number),
        .field_value  (field_value),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item)
    );

    ccfe_field_update u_field_update (
        .cur     (state_reg),
        .item    (item),
        .timeout (timeout_reg),
        .nxt     (state_upd)
    );

    assign state_next     = advance ? state_upd : state_reg;
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    assign timeout_next   = cfg_we ? cfg_wdata : timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{month: 4'd1, day: 5'd1, year: YEAR_MIN, hour: '0,
                           minute: '0, second: '0, selected: FLD_NONE,
                           buttons: 1'b0, idle: '0};
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            timeout_reg   <= timeout_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign month_now       = state_reg.month;
    assign day_now         = state_reg.day;
    assign year_now        = state_reg.year;
    assign hour_now        = state_reg.hour;
    assign minute_now      = state_reg.minute;
    assign second_now      = state_reg.second;
    assign selected_now    = state_reg.selected;
    assign buttons_visible = state_reg.buttons;

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        year_now >= YEAR_MIN && year_now <= YEAR_MAX)
        else $error("year out of range");

    a_sel_buttons: assert property (@(posedge clk) disable iff (!rst_n)
        buttons_visible == (selected_now != FLD_NONE))
        else $error("selection and buttons disagree");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && item_valid))
        else $error("input stalled without a held result");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(state_reg))
        else $error("calendar state moved under a stalled result");

endmodule

FILE: bench/clock_calendar_field_editor_unit_tb.sv
// Self-checking bench for clock_calendar_field_editor_unit: directed and random
// command streams with random gaps and stalls, checked against a cycle-free model.
// Depends on ccfe_pkg and the clock_calendar_field_editor_unit RTL.
module clock_calendar_field_editor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccfe_pkg::*;

    localparam int MONTHS_PER_YEAR = 12;
    localparam int FEBRUARY        = 2;
    localparam int LEAP_FEB_DAYS   = 29;
    localparam int LAST_DAY        = 31;
    localparam int LAST_HOUR       = 23;
    localparam int LAST_MINUTE     = 59;
    localparam int MONTH_LEN [12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int MAX_WAIT        = 13;
    localparam int PHASE_ITEMS     = 280;

    localparam logic [CMD_W-1:0] CMD_TOP     = '1;
    localparam logic [FLD_W-1:0] FLD_INVALID = '1;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [FLD_W-1:0]   selected;
        logic               buttons;
        logic [IDLE_W-1:0]  idle;
    } calendar_t;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     command      = '0;
    logic [FLD_W-1:0]     field_number = '0;
    logic [VAL_W-1:0]     field_value  = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [MONTH_W-1:0]   month_now;
    logic [DAY_W-1:0]     day_now;
    logic [YEAR_W-1:0]    year_now;
    logic [HOUR_W-1:0]    hour_now;
    logic [MIN_W-1:0]     minute_now;
    logic [SEC_W-1:0]     second_now;
    logic [FLD_W-1:0]     selected_now;
    logic                 buttons_visible;
    logic                 cfg_we       = 1'b0;
    logic [IDLE_W-1:0]    cfg_wdata    = '0;

    item_t                pending_cmds[$];
    calendar_t            expected_cal[$];
    calendar_t            cal;
    logic [IDLE_W-1:0]    timeout_ticks = TIMEOUT_RESET;
    logic                 in_taken      = 1'b0;
    logic                 out_taken     = 1'b0;
    bit                   quiet_send    = 1'b0;
    bit                   quiet_recv    = 1'b0;
    int                   send_wait     = 0;
    int                   stall_wait    = 0;
    int                   items_queued  = 0;
    int                   results_done  = 0;
    int                   mismatches    = 0;
    int                   timeouts_seen = 0;
    int                   settings_used = 1;

    clock_calendar_field_editor_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .field_number    (field_number),
        .field_value     (field_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .month_now       (month_now),
        .day_now         (day_now),
        .year_now        (year_now),
        .hour_now        (hour_now),
        .minute_now      (minute_now),
        .second_now      (second_now),
        .selected_now    (selected_now),
        .buttons_visible (buttons_visible),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int month_days(int m, int y);
        int d;
        if (m < 1 || m > MONTHS_PER_YEAR)
            m = 1;
        d = MONTH_LEN[m - 1];
        if (m == FEBRUARY && y % 4 == 0)
            d = LEAP_FEB_DAYS;
        return d;
    endfunction

    function automatic calendar_t calendar_after(calendar_t s, item_t it,
                                                 logic [IDLE_W-1:0] limit);
        calendar_t n;
        bit        up;
        int        mlen;
        n = s;
        up = (it.cmd == CMD_UP);
        mlen = month_days(int'(s.month), int'(s.year));
        case (it.cmd)
            CMD_SELECT:
                if (it.fld >= FLD_MONTH && it.fld <= FLD_SECOND)
                begin
                    n.selected = it.fld;
                    n.buttons  = 1'b1;
                    n.idle     = '0;
                end
            CMD_UP, CMD_DOWN:
            begin
                n.idle = '0;
                case (s.selected)
                    FLD_MONTH:
                        n.month = MONTH_W'(up ?
                                  ((s.month >= MONTHS_PER_YEAR) ? 1 : s.month + 1) :
                                  ((s.month <= 1) ? MONTHS_PER_YEAR : s.month - 1));
                    FLD_DAY:
                        n.day = DAY_W'(up ? ((s.day + 1 > mlen) ? 1 : s.day + 1)
                                          : ((s.day <= 1) ? mlen : s.day - 1));
                    FLD_YEAR:
                        n.year = YEAR_W'(up ? ((s.year < YEAR_MAX) ? s.year + 1 : s.year)
                                            : ((s.year > YEAR_MIN) ? s.year - 1 : s.year));
                    FLD_HOUR:
                        n.hour = HOUR_W'(up ? ((s.hour >= LAST_HOUR) ? 0 : s.hour + 1)
                                            : ((s.hour == 0 || s.hour > LAST_HOUR) ?
                                               LAST_HOUR : s.hour - 1));
                    FLD_MINUTE:
                        n.minute = MIN_W'(up ?
                                   ((s.minute >= LAST_MINUTE) ? 0 : s.minute + 1) :
                                   ((s.minute == 0 || s.minute > LAST_MINUTE) ?
                                    LAST_MINUTE : s.minute - 1));
                    FLD_SECOND:
                        n.second = SEC_W'(up ?
                                   ((s.second >= LAST_MINUTE) ? 0 : s.second + 1) :
                                   ((s.second == 0 || s.second > LAST_MINUTE) ?
                                    LAST_MINUTE : s.second - 1));
                    default: ;
                endcase
            end
            CMD_TICK:
                if (s.buttons)
                begin
                    if (s.idle != IDLE_MAX)
                        n.idle = s.idle + 1'b1;
                    if (n.idle >= limit)
                    begin
                        n.selected = FLD_NONE;
                        n.buttons  = 1'b0;
                        n.idle     = '0;
                    end
                end
            CMD_WRITE:
                case (it.fld)
                    FLD_MONTH:
                        if (it.val >= 1 && it.val <= MONTHS_PER_YEAR)
                            n.month = it.val[MONTH_W-1:0];
                    FLD_DAY:
                        if (it.val >= 1 && it.val <= LAST_DAY)
                            n.day = it.val[DAY_W-1:0];
                    FLD_YEAR:
                        if (it.val >= YEAR_MIN && it.val <= YEAR_MAX)
                            n.year = it.val;
                    FLD_HOUR:
                        if (it.val <= LAST_HOUR)
                            n.hour = it.val[HOUR_W-1:0];
                    FLD_MINUTE:
                        if (it.val <= LAST_MINUTE)
                            n.minute = it.val[MIN_W-1:0];
                    FLD_SECOND:
                        if (it.val <= LAST_MINUTE)
                            n.second = it.val[SEC_W-1:0];
                    default: ;
                endcase
            default: ;
        endcase
        return n;
    endfunction

    task automatic report_error(string msg);
        mismatches++;
        if (mismatches <= 30)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_error($sformatf("transaction %0d: %s = %0d, expected %0d",
                                   results_done, name, got, want));
    endtask

    // Input side: inputs move only on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                item_t it;
                it = pending_cmds.pop_front();
                command      <= it.cmd;
                field_number <= it.fld;
                field_value  <= it.val;
                in_valid     <= 1'b1;
                send_wait = quiet_send ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side back-pressure, one wait drawn per result.
    always @(negedge clk)
    begin
        if (out_taken)
            stall_wait = quiet_recv ? 0 : $urandom_range(0, MAX_WAIT);
        if (out_valid === 1'b1 && stall_wait > 0)
        begin
            stall_wait--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Sampling, prediction and checking on the rising edge.
    always @(posedge clk)
    begin
        in_taken  <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        if (rst_n)
        begin
            if (cfg_we)
                timeout_ticks = cfg_wdata;
            if (out_valid && !out_stall)
            begin
                results_done++;
                if (expected_cal.size() == 0)
                    report_error($sformatf("transaction %0d: result with nothing outstanding",
                                           results_done));
                else
                begin
                    calendar_t want;
                    want = expected_cal.pop_front();
                    check_field("month_now", 16'(month_now), 16'(want.month));
                    check_field("day_now", 16'(day_now), 16'(want.day));
                    check_field("year_now", 16'(year_now), 16'(want.year));
                    check_field("hour_now", 16'(hour_now), 16'(want.hour));
                    check_field("minute_now", 16'(minute_now), 16'(want.minute));
                    check_field("second_now", 16'(second_now), 16'(want.second));
                    check_field("selected_now", 16'(selected_now), 16'(want.selected));
                    check_field("buttons_visible", 16'(buttons_visible), 16'(want.buttons));
                end
            end
            if (in_valid && !in_stall)
            begin
                calendar_t next;
                next = calendar_after(cal, '{cmd: command, fld: field_number,
                                             val: field_value}, timeout_ticks);
                if (command == CMD_TICK && cal.buttons && !next.buttons)
                    timeouts_seen++;
                cal = next;
                expected_cal.push_back(cal);
            end
        end
    end

    task automatic add_item(logic [CMD_W-1:0] cmd, logic [FLD_W-1:0] fld,
                            logic [VAL_W-1:0] val);
        pending_cmds.push_back('{cmd: cmd, fld: fld, val: val});
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_done < items_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_timeout(logic [IDLE_W-1:0] ticks);
        wait_drained();
        cfg_wdata <= ticks;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // An editing session: select a field, then mostly adjust, idle and write.
    task automatic queue_session(int count);
        logic [CMD_W-1:0] cmd;
        logic [FLD_W-1:0] fld;
        logic [VAL_W-1:0] val;
        int               r;
        add_item(CMD_SELECT, FLD_W'($urandom_range(FLD_MONTH, FLD_SECOND)),
                 VAL_W'($urandom));
        for (int i = 1; i < count; i++)
        begin
            r   = $urandom_range(0, 99);
            fld = FLD_W'($urandom);
            val = VAL_W'($urandom);
            if (r < 10)
            begin
                cmd = CMD_SELECT;
                if ($urandom_range(0, 5) != 0)
                    fld = FLD_W'($urandom_range(FLD_MONTH, FLD_SECOND));
            end
            else if (r < 35)
                cmd = CMD_UP;
            else if (r < 55)
                cmd = CMD_DOWN;
            else if (r < 78)
                cmd = CMD_TICK;
            else if (r < 95)
            begin
                cmd = CMD_WRITE;
                if ($urandom_range(0, 7) != 0)
                    fld = FLD_W'($urandom_range(FLD_MONTH, FLD_SECOND));
                if ($urandom_range(0, 3) != 0)
                    case (fld)
                        FLD_MONTH:  val = VAL_W'($urandom_range(1, MONTHS_PER_YEAR));
                        FLD_DAY:    val = VAL_W'($urandom_range(1, LAST_DAY));
                        FLD_YEAR:   val = VAL_W'(($urandom_range(0, 2) == 0) ?
                                          (($urandom_range(0, 1) == 0) ? YEAR_MIN : YEAR_MAX) :
                                          $urandom_range(YEAR_MIN, YEAR_MAX));
                        FLD_HOUR:   val = VAL_W'($urandom_range(0, LAST_HOUR));
                        FLD_MINUTE: val = VAL_W'($urandom_range(0, LAST_MINUTE));
                        FLD_SECOND: val = VAL_W'($urandom_range(0, LAST_MINUTE));
                        default: ;
                    endcase
            end
            else
                cmd = CMD_W'($urandom_range(CMD_WRITE + 1, CMD_TOP));
            add_item(cmd, fld, val);
        end
    endtask

    initial
    begin
        logic [IDLE_W-1:0] timeouts [6];
        int                left;
        int                n;
        cal = '{month: 1, day: 1, year: YEAR_MIN, default: '0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle commands, leap February, short months, wraps and limits.
        add_item(CMD_TICK, FLD_NONE, '0);
        add_item(CMD_UP, FLD_NONE, '0);
        add_item(CMD_SELECT, FLD_INVALID, '0);
        add_item(CMD_WRITE, FLD_MONTH, VAL_W'(FEBRUARY));
        add_item(CMD_SELECT, FLD_DAY, '0);
        add_item(CMD_DOWN, FLD_NONE, '0);
        add_item(CMD_UP, FLD_NONE, '0);
        add_item(CMD_WRITE, FLD_YEAR, VAL_W'(YEAR_MIN + 1));
        add_item(CMD_DOWN, FLD_NONE, '0);
        add_item(CMD_WRITE, FLD_DAY, VAL_W'(LAST_DAY));
        add_item(CMD_WRITE, FLD_MONTH, VAL_W'(4));
        add_item(CMD_UP, FLD_NONE, '0);
        add_item(CMD_WRITE, FLD_DAY, VAL_W'(LAST_DAY));
        add_item(CMD_DOWN, FLD_NONE, '0);
        add_item(CMD_SELECT, FLD_MONTH, '0);
        add_item(CMD_WRITE, FLD_MONTH, VAL_W'(MONTHS_PER_YEAR));
        add_item(CMD_UP, FLD_NONE, '0);
        add_item(CMD_DOWN, FLD_NONE, '0);
        add_item(CMD_SELECT, FLD_YEAR, '0);
        add_item(CMD_DOWN, FLD_NONE, '0);
        add_item(CMD_DOWN, FLD_NONE, '0);
        add_item(CMD_WRITE, FLD_YEAR, YEAR_MAX);
        add_item(CMD_UP, FLD_NONE, '0);
        add_item(CMD_SELECT, FLD_HOUR, '0);
        add_item(CMD_DOWN, FLD_NONE, '0);
        add_item(CMD_UP, FLD_NONE, '0);
        add_item(CMD_WRITE, FLD_MONTH, VAL_W'(MONTHS_PER_YEAR + 1));
        add_item(CMD_WRITE, FLD_YEAR, VAL_W'(YEAR_MIN - 1));
        add_item(CMD_TOP, FLD_INVALID, '1);

        timeouts = '{16'd1, 16'hFFFF, 16'd2, 16'd5, 16'd0, TIMEOUT_RESET};
        timeouts[4] = IDLE_W'($urandom_range(3, 15));
        foreach (timeouts[p])
        begin
            set_timeout(timeouts[p]);
            settings_used++;
            left = PHASE_ITEMS;
            while (left > 0)
            begin
                n = $urandom_range(8, 40);
                if (n > left)
                    n = left;
                quiet_send = ($urandom_range(0, 3) == 0);
                quiet_recv = ($urandom_range(0, 3) == 0);
                queue_session(n);
                left -= n;
                while (pending_cmds.size() != 0)
                    @(posedge clk);
                if ($urandom_range(0, 4) == 0)
                begin
                    wait_drained();
                    @(posedge clk);
                end
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (expected_cal.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_cal.size()));
        $display("%0d transactions checked under %0d idle timeout settings, %0d selection timeouts",
                 results_done, settings_used, timeouts_seen);
        if (mismatches == 0)
            $display("clock_calendar_field_editor_unit regression: pass");
        else
            $display("clock_calendar_field_editor_unit regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("clock_calendar_field_editor_unit regression: fail");
        $finish;
    end

endmodule
